// ===== rtl/bisection_root_search_macros.svh =====
// Assertion helpers for the RTL of the bisection root search.
`ifndef BISECTION_ROOT_SEARCH_MACROS_SVH
`define BISECTION_ROOT_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BISR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BISR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bisr_pkg.sv =====
package bisr_pkg;

    // Fixed field widths.
    localparam int STATUS_W    = 3;
    localparam int ABS_TOL_W   = 31;
    localparam int REL_TOL_W   = 16;
    localparam int LIMIT_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;
    localparam int FRAC_BITS   = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ABS_TOL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REL_TOL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT   = 2'd2;

    // Configuration reset values.
    localparam logic [ABS_TOL_W-1:0] ABS_TOL_RESET = 31'd1;
    localparam logic [REL_TOL_W-1:0] REL_TOL_RESET = 16'd0;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 8'd64;

    // Request kinds carried in the input tuser.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_VALUE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_EVAL    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CONV    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOSIGN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

    // Sign classes of a function value.
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_WAIT_LO = 4'b0010,
        PH_WAIT_HI = 4'b0100,
        PH_BISECT  = 4'b1000
    } phase_t;

endpackage

// ===== rtl/bisr_conv.sv =====
// Convergence test: |pos_end - neg_end| < abs_tol + rel_tol * |neg_end|.
module bisr_conv
    import bisr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic signed [VALUE_WIDTH-1:0] neg_end,
    input  logic signed [VALUE_WIDTH-1:0] pos_end,
    input  logic        [ABS_TOL_W-1:0]   abs_tol,
    input  logic        [REL_TOL_W-1:0]   rel_tol,
    output logic                          converged
);

    localparam int PROD_W = VALUE_WIDTH + REL_TOL_W;
    localparam int TOL_W  = ((VALUE_WIDTH > ABS_TOL_W) ? VALUE_WIDTH : ABS_TOL_W) + 1;

    logic signed [VALUE_WIDTH:0] diff;
    logic signed [VALUE_WIDTH:0] neg_ext;
    logic        [VALUE_WIDTH:0] width_abs;
    logic        [VALUE_WIDTH:0] mag_abs;
    logic        [PROD_W-1:0]    prod;
    logic        [TOL_W-1:0]     tol;

    assign diff    = {pos_end[VALUE_WIDTH-1], pos_end} - {neg_end[VALUE_WIDTH-1], neg_end};
    assign neg_ext = {neg_end[VALUE_WIDTH-1], neg_end};

    assign width_abs = diff[VALUE_WIDTH] ? -diff : diff;
    assign mag_abs   = neg_ext[VALUE_WIDTH] ? -neg_ext : neg_ext;

    // The magnitude fits in VALUE_WIDTH unsigned bits, the product is truncated to Q16.16.
    assign prod = PROD_W'(mag_abs[VALUE_WIDTH-1:0]) * PROD_W'(rel_tol);
    assign tol  = TOL_W'(prod[PROD_W-1:FRAC_BITS]) + TOL_W'(abs_tol);

    assign converged = TOL_W'(width_abs[VALUE_WIDTH-1:0]) < tol;

endmodule

// ===== rtl/bisection_root_search.sv =====
// Bisection root search: an accepted input beat is registered in the input stage, its result
// in the result stage. Throughput is one input beat per cycle unless results stall; the bracket
// update for a function value is done in one pass through a midpoint adder, one 16-bit-by-value
// multiplier and one compare. Reset (rst_n low, asynchronous) empties both pipeline stages,
// sets the search idle and restores the tolerances and iteration limit to their default values.
`include "bisection_root_search_macros.svh"

module bisection_root_search
    import bisr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_WIDTH = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, from bit 0 up: lower_bound, upper_bound, func_value, zero padding
    input  logic [((3*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: req_type
    input  logic                               s_axis_tuser,

    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata, from bit 0 up: eval_point, root, zero padding
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // tuser: status
    output logic [STATUS_W-1:0]                m_axis_tuser,

    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [CFG_INDEX_W-1:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]              cfg_data
);

    localparam int OUT_DATA_W = ((2*VALUE_WIDTH+7)/8)*8;
    localparam int CMP_W      = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers. Writes are taken in every cycle; an index
    // beyond the register list is accepted and dropped.
    // ------------------------------------------------------------------
    logic [ABS_TOL_W-1:0] abs_tol_reg;
    logic [REL_TOL_W-1:0] rel_tol_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_tol_reg <= ABS_TOL_RESET;
            rel_tol_reg <= REL_TOL_RESET;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ABS_TOL: abs_tol_reg <= cfg_data[ABS_TOL_W-1:0];
                CFG_REL_TOL: rel_tol_reg <= cfg_data[REL_TOL_W-1:0];
                CFG_LIMIT:   limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register stage. It takes a new beat whenever it is empty or
    // its current beat moves on to the result register in the same cycle,
    // so a waiting result blocks a new beat only when this stage is full and the result is held.
    // ------------------------------------------------------------------
    logic                          in_valid_reg;
    logic                          in_req_reg;
    logic signed [VALUE_WIDTH-1:0] in_lower_reg;
    logic signed [VALUE_WIDTH-1:0] in_upper_reg;
    logic signed [VALUE_WIDTH-1:0] in_value_reg;

    logic out_valid_reg;
    logic step_fire;

    assign step_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_req_reg   <= s_axis_tuser;
            in_lower_reg <= s_axis_tdata[VALUE_WIDTH-1:0];
            in_upper_reg <= s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
            in_value_reg <= s_axis_tdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH];
        end
    end

    // ------------------------------------------------------------------
    // Search state.
    // ------------------------------------------------------------------
    phase_t                        phase_reg,   phase_next;
    logic signed [VALUE_WIDTH-1:0] neg_end_reg, neg_end_next;
    logic signed [VALUE_WIDTH-1:0] pos_end_reg, pos_end_next;
    logic signed [VALUE_WIDTH-1:0] held_reg,    held_next;
    logic        [1:0]             fsign_reg,   fsign_next;
    logic        [COUNT_WIDTH-1:0] count_reg,   count_next;

    // Classifies a function value as zero, positive or negative.
    function automatic logic [1:0] sign_of(input logic signed [VALUE_WIDTH-1:0] v);
        logic [1:0] s;
        if (v == '0)
            s = SIGN_ZERO;
        else if (v[VALUE_WIDTH-1])
            s = SIGN_NEG;
        else
            s = SIGN_POS;
        return s;
    endfunction

    // Floor of (a + b) / 2; the sum is one bit wider, so it never overflows.
    function automatic logic signed [VALUE_WIDTH-1:0] midpoint(
        input logic signed [VALUE_WIDTH-1:0] a,
        input logic signed [VALUE_WIDTH-1:0] b
    );
        logic [VALUE_WIDTH:0] s;
        s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
        return s[VALUE_WIDTH:1];
    endfunction

    // Candidate bracket for this beat. While the endpoint values are being
    // checked, the ends are ordered by the sign of f(lower). While bisecting,
    // the current midpoint replaces the end whose sign it shares.
    logic signed [VALUE_WIDTH-1:0] mid_cur;
    logic signed [VALUE_WIDTH-1:0] cand_neg;
    logic signed [VALUE_WIDTH-1:0] cand_pos;
    logic signed [VALUE_WIDTH-1:0] mid_next;
    logic                          value_neg;
    logic [1:0]                    value_sign;
    logic                          no_sign_change;
    logic [COUNT_WIDTH-1:0]        count_sat;
    logic                          limit_hit;
    logic                          conv_hit;

    assign mid_cur    = midpoint(neg_end_reg, pos_end_reg);
    assign value_neg  = in_value_reg[VALUE_WIDTH-1];
    assign value_sign = sign_of(in_value_reg);

    always_comb
    begin
        if (phase_reg == PH_BISECT)
        begin
            cand_neg = value_neg ? mid_cur : neg_end_reg;
            cand_pos = value_neg ? pos_end_reg : mid_cur;
        end
        else if (fsign_reg == SIGN_POS)
        begin
            cand_neg = held_reg;
            cand_pos = neg_end_reg;
        end
        else
        begin
            cand_neg = neg_end_reg;
            cand_pos = held_reg;
        end
    end

    assign mid_next       = midpoint(cand_neg, cand_pos);
    assign no_sign_change = (fsign_reg != SIGN_ZERO) && (fsign_reg == value_sign);
    assign count_sat      = (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
    assign limit_hit      = (CMP_W'(count_sat) >= CMP_W'(limit_reg)) || (count_sat == CNT_MAX);

    bisr_conv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_conv (
        .neg_end   (cand_neg),
        .pos_end   (cand_pos),
        .abs_tol   (abs_tol_reg),
        .rel_tol   (rel_tol_reg),
        .converged (conv_hit)
    );

    // Next state and result for the beat in the input register.
    logic [STATUS_W-1:0]           step_status;
    logic signed [VALUE_WIDTH-1:0] step_eval;
    logic signed [VALUE_WIDTH-1:0] step_root;

    always_comb
    begin
        phase_next   = phase_reg;
        neg_end_next = neg_end_reg;
        pos_end_next = pos_end_reg;
        held_next    = held_reg;
        fsign_next   = fsign_reg;
        count_next   = count_reg;
        step_status  = ST_IGNORED;
        step_eval    = '0;
        step_root    = '0;

        if (in_req_reg == REQ_START)
        begin
            // A start always aborts whatever search is running.
            neg_end_next = in_lower_reg;
            held_next    = in_upper_reg;
            fsign_next   = SIGN_ZERO;
            count_next   = '0;
            phase_next   = PH_WAIT_LO;
            step_status  = ST_EVAL;
            step_eval    = in_lower_reg;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT_LO:
                begin
                    fsign_next  = value_sign;
                    phase_next  = PH_WAIT_HI;
                    step_status = ST_EVAL;
                    step_eval   = held_reg;
                end
                PH_WAIT_HI:
                begin
                    if (no_sign_change)
                    begin
                        phase_next  = PH_IDLE;
                        step_status = ST_NOSIGN;
                    end
                    else
                    begin
                        neg_end_next = cand_neg;
                        pos_end_next = cand_pos;
                        count_next   = '0;
                        if (limit_reg == '0)
                        begin
                            phase_next  = PH_IDLE;
                            step_status = ST_LIMIT;
                            step_root   = mid_next;
                        end
                        else
                        begin
                            phase_next  = PH_BISECT;
                            step_status = ST_EVAL;
                            step_eval   = mid_next;
                        end
                    end
                end
                PH_BISECT:
                begin
                    neg_end_next = cand_neg;
                    pos_end_next = cand_pos;
                    count_next   = count_sat;
                    if (conv_hit)
                    begin
                        phase_next  = PH_IDLE;
                        step_status = ST_CONV;
                        step_root   = mid_next;
                    end
                    else if (limit_hit)
                    begin
                        phase_next  = PH_IDLE;
                        step_status = ST_LIMIT;
                        step_root   = mid_next;
                    end
                    else
                    begin
                        step_status = ST_EVAL;
                        step_eval   = mid_next;
                    end
                end
                PH_IDLE:
                begin
                    step_status = ST_IGNORED;
                end
                default:
                begin
                    step_status = ST_IGNORED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            neg_end_reg <= '0;
            pos_end_reg <= '0;
            held_reg    <= '0;
            fsign_reg   <= SIGN_ZERO;
            count_reg   <= '0;
        end
        else if (step_fire)
        begin
            phase_reg   <= phase_next;
            neg_end_reg <= neg_end_next;
            pos_end_reg <= pos_end_next;
            held_reg    <= held_next;
            fsign_reg   <= fsign_next;
            count_reg   <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register. It holds a beat until the consumer takes it.
    // ------------------------------------------------------------------
    logic [STATUS_W-1:0]           out_status_reg;
    logic signed [VALUE_WIDTH-1:0] out_eval_reg;
    logic signed [VALUE_WIDTH-1:0] out_root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            out_status_reg <= step_status;
            out_eval_reg   <= step_eval;
            out_root_reg   <= step_root;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_root_reg, out_eval_reg});

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `BISR_ASSERT_SAME(a_full_stall, clk, rst_n,
        in_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready,
        "input taken while both stages are full and stalled")

    `BISR_ASSERT_SAME(a_count_bound, clk, rst_n,
        phase_reg == PH_BISECT, count_reg != CNT_MAX,
        "bisecting with a saturated iteration count")

    `BISR_ASSERT_NEXT(a_final_idle, clk, rst_n,
        step_fire && (step_status == ST_CONV || step_status == ST_LIMIT
                      || step_status == ST_NOSIGN),
        phase_reg == PH_IDLE,
        "search not idle after a final status")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import bisr_pkg::*;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 8;
    localparam int IN_DATA_W = ((3*VALUE_W+7)/8)*8;
    localparam int OUT_DATA_W = ((2*VALUE_W+7)/8)*8;
    // Two pipeline stages inside the block, plus margin.
    localparam int SETTLE_CYCLES = 4;
    // Length of the deliberate receiver hold-off used to back the block up.
    localparam int HOLD_OFF_CYCLES = 80;

    // One input beat as the function evaluator sees it.
    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] fv;
    } request_t;

    // One result beat.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  eval_point;
        logic [VALUE_W-1:0]  root;
    } answer_t;

    // A directed row. When typed is set, the answer fields are the expected
    // result; otherwise the bracket predictor supplies it.
    typedef struct packed {
        logic                kind;
        logic [VALUE_W-1:0]  lo;
        logic [VALUE_W-1:0]  hi;
        logic [VALUE_W-1:0]  fv;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  eval_point;
        logic [VALUE_W-1:0]  root;
    } table_row_t;

    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN,
        SINK_SPARSE
    } sink_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata, from bit 0 up: lower_bound, upper_bound, func_value
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: req_type
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata, from bit 0 up: eval_point, root
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: status
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bisection_root_search #(
        .VALUE_WIDTH (VALUE_W),
        .COUNT_WIDTH (COUNT_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predictor copy of the configuration registers.
    logic [ABS_TOL_W-1:0] abs_tol;
    logic [REL_TOL_W-1:0] rel_tol;
    logic [LIMIT_W-1:0]   iter_limit;

    // Predictor copy of the search state.
    logic [VALUE_W-1:0] neg_end;
    logic [VALUE_W-1:0] pos_end;
    logic [VALUE_W-1:0] held_upper;
    logic [1:0]         first_sign;
    logic [COUNT_W-1:0] mid_count;
    phase_t             search_phase;

    answer_t    pending_answers[$];
    int         mismatches;
    int         useful_beats;
    int         searches_started;
    int         status_tally [5];
    int         burst_left;
    bit         gaps_on;
    logic       hold_req;
    sink_mode_t sink_mode;

    // Directed rows, run with the reset configuration: absolute tolerance of
    // one LSB, no relative tolerance, 64 midpoints allowed.
    table_row_t directed_rows [25] = '{
        // Value while idle right after reset is ignored.
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
         1'b1, ST_IGNORED, 32'h0, 32'h0},
        // Widest bracket: most negative to most positive.
        {REQ_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
         1'b1, ST_EVAL, 32'h8000_0000, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
         1'b1, ST_EVAL, 32'h7FFF_FFFF, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
         1'b0, ST_EVAL, 32'h0, 32'h0},
        // A zero midpoint value moves the positive end.
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
         1'b0, ST_EVAL, 32'h0, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
         1'b0, ST_EVAL, 32'h0, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
         1'b0, ST_EVAL, 32'h0, 32'h0},
        // A start in the middle of a search aborts it.
        {REQ_START, 32'h0005_0000, 32'hFFFB_0000, 32'hFFFF_FFFF,
         1'b1, ST_EVAL, 32'h0005_0000, 32'h0},
        {REQ_VALUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000,
         1'b1, ST_EVAL, 32'hFFFB_0000, 32'h0},
        // Positive lower end: the bracket ends get swapped.
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000,
         1'b0, ST_EVAL, 32'h0, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
         1'b0, ST_EVAL, 32'h0, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
         1'b0, ST_EVAL, 32'h0, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h8000_0001,
         1'b0, ST_EVAL, 32'h0, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFE,
         1'b0, ST_EVAL, 32'h0, 32'h0},
        // Both ends positive: rejected.
        {REQ_START, 32'h0000_0001, 32'h0000_0002, 32'h0000_0000,
         1'b1, ST_EVAL, 32'h0000_0001, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0005,
         1'b1, ST_EVAL, 32'h0000_0002, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
         1'b1, ST_NOSIGN, 32'h0, 32'h0},
        // Idle again after the rejection.
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
         1'b1, ST_IGNORED, 32'h0, 32'h0},
        // Both ends negative: rejected.
        {REQ_START, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000,
         1'b1, ST_EVAL, 32'hFFFF_FFFF, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
         1'b1, ST_EVAL, 32'h0000_0001, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
         1'b1, ST_NOSIGN, 32'h0, 32'h0},
        // Both values zero is a valid bracket of zero width.
        {REQ_START, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
         1'b1, ST_EVAL, 32'h0000_0000, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
         1'b1, ST_EVAL, 32'h0000_0000, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
         1'b0, ST_EVAL, 32'h0, 32'h0},
        {REQ_VALUE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
         1'b0, ST_EVAL, 32'h0, 32'h0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [1:0] sign_class(input logic [VALUE_W-1:0] v);
        if (v == '0)
            return SIGN_ZERO;
        return v[VALUE_W-1] ? SIGN_NEG : SIGN_POS;
    endfunction

    // Exact floor((a + b) / 2) on signed values.
    function automatic logic [VALUE_W-1:0] bracket_mid(input logic [VALUE_W-1:0] a,
                                                       input logic [VALUE_W-1:0] b);
        logic [VALUE_W:0] total;
        total = {a[VALUE_W-1], a} + {b[VALUE_W-1], b};
        return total[VALUE_W:1];
    endfunction

    // Width test: |pos - neg| < abs_tol + floor(rel_tol * |neg| / 2^16).
    function automatic bit bracket_closed();
        logic [VALUE_W:0]   span;
        logic [VALUE_W-1:0] mag;
        logic [63:0]        tol;
        span = {pos_end[VALUE_W-1], pos_end} - {neg_end[VALUE_W-1], neg_end};
        if (span[VALUE_W])
            span = -span;
        mag = neg_end[VALUE_W-1] ? -neg_end : neg_end;
        tol = (({32'b0, mag} * {48'b0, rel_tol}) >> FRAC_BITS) + {33'b0, abs_tol};
        return {31'b0, span} < tol;
    endfunction

    // Advances the predicted search state by one beat and returns the answer.
    function automatic answer_t bisect_step(input request_t rq);
        answer_t            ans;
        logic [1:0]         second_sign;
        logic [VALUE_W-1:0] probe;
        ans = '0;
        ans.status = ST_EVAL;
        if (rq.kind == REQ_START)
        begin
            neg_end = rq.lo;
            held_upper = rq.hi;
            first_sign = SIGN_ZERO;
            mid_count = '0;
            search_phase = PH_WAIT_LO;
            ans.eval_point = rq.lo;
            return ans;
        end
        case (search_phase)
            PH_WAIT_LO:
            begin
                first_sign = sign_class(rq.fv);
                search_phase = PH_WAIT_HI;
                ans.eval_point = held_upper;
            end
            PH_WAIT_HI:
            begin
                second_sign = sign_class(rq.fv);
                if (first_sign != SIGN_ZERO && first_sign == second_sign)
                begin
                    search_phase = PH_IDLE;
                    ans.status = ST_NOSIGN;
                end
                else
                begin
                    // Keep the non-positive end as neg_end.
                    if (first_sign == SIGN_POS)
                    begin
                        pos_end = neg_end;
                        neg_end = held_upper;
                    end
                    else
                        pos_end = held_upper;
                    mid_count = '0;
                    if (iter_limit == '0)
                    begin
                        search_phase = PH_IDLE;
                        ans.status = ST_LIMIT;
                        ans.root = bracket_mid(neg_end, pos_end);
                    end
                    else
                    begin
                        search_phase = PH_BISECT;
                        ans.eval_point = bracket_mid(neg_end, pos_end);
                    end
                end
            end
            PH_BISECT:
            begin
                probe = bracket_mid(neg_end, pos_end);
                if (rq.fv[VALUE_W-1])
                    neg_end = probe;
                else
                    pos_end = probe;
                if (mid_count != '1)
                    mid_count++;
                if (bracket_closed())
                begin
                    search_phase = PH_IDLE;
                    ans.status = ST_CONV;
                    ans.root = bracket_mid(neg_end, pos_end);
                end
                else if (mid_count >= iter_limit || mid_count == '1)
                begin
                    search_phase = PH_IDLE;
                    ans.status = ST_LIMIT;
                    ans.root = bracket_mid(neg_end, pos_end);
                end
                else
                    ans.eval_point = bracket_mid(neg_end, pos_end);
            end
            default:
                ans.status = ST_IGNORED;
        endcase
        return ans;
    endfunction

    // Offers one beat, waits for it to be taken, and records what should come
    // back. When gaps are on, the sender drops tvalid between bursts.
    task automatic send_beat(input request_t rq, input bit typed, input answer_t typed_ans);
        answer_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rq.kind;
        s_axis_tdata <= {rq.fv, rq.hi, rq.lo};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = bisect_step(rq);
        if (predicted.status != ST_IGNORED)
            useful_beats++;
        pending_answers.push_back(typed ? typed_ans : predicted);
        burst_left--;
        if (gaps_on && burst_left <= 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    // Waits until every expected result has arrived and the pipeline is empty.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers back to back; only called while idle.
    task automatic set_search_limits(input logic [ABS_TOL_W-1:0] abs_value,
                                     input logic [REL_TOL_W-1:0] rel_value,
                                     input logic [LIMIT_W-1:0]   limit_value);
        logic [CFG_DATA_W-1:0] words [3];
        logic [CFG_INDEX_W-1:0] regs [3];
        words[0] = abs_value;
        words[1] = {15'b0, rel_value};
        words[2] = {23'b0, limit_value};
        regs[0] = CFG_ABS_TOL;
        regs[1] = CFG_REL_TOL;
        regs[2] = CFG_LIMIT;
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= words[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        abs_tol = abs_value;
        rel_tol = rel_value;
        iter_limit = limit_value;
    endtask

    function automatic logic [VALUE_W-1:0] extreme_value();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Zero now and then, otherwise an even split of positive and negative.
    function automatic logic [1:0] random_class();
        if ($urandom_range(0, 15) == 0)
            return SIGN_ZERO;
        return $urandom_range(0, 1) ? SIGN_POS : SIGN_NEG;
    endfunction

    function automatic logic [VALUE_W-1:0] value_of_class(input logic [1:0] cls);
        logic [VALUE_W-1:0] v;
        if (cls == SIGN_ZERO)
            return '0;
        case ($urandom_range(0, 9))
            0: v = (cls == SIGN_POS) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: v = (cls == SIGN_POS) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            default:
            begin
                v = $urandom;
                v[VALUE_W-1] = (cls == SIGN_NEG);
                if (v == '0)
                    v = 32'h0000_0001;
            end
        endcase
        return v;
    endfunction

    // One search: start beat, both endpoint values, then n_mid midpoint values.
    // Unless the bracket is forced, a share of endpoint pairs share a sign or
    // contain a zero.
    task automatic one_search(input int n_mid, input bit force_bracket);
        request_t   rq;
        answer_t    none;
        logic [1:0] first_cls;
        logic [1:0] second_cls;
        int         pick;
        none = '0;
        rq.kind = REQ_START;
        rq.fv = $urandom;
        case ($urandom_range(0, 4))
            0, 1:
            begin
                rq.lo = $urandom;
                rq.hi = $urandom;
            end
            2:
            begin
                rq.lo = extreme_value();
                rq.hi = extreme_value();
            end
            default:
            begin
                // Narrow bracket, so tolerances are reached quickly.
                rq.lo = $urandom;
                rq.hi = rq.lo + $urandom_range(0, 32'h0004_0000);
            end
        endcase
        searches_started++;
        send_beat(rq, 1'b0, none);
        pick = force_bracket ? 0 : $urandom_range(0, 19);
        first_cls = $urandom_range(0, 1) ? SIGN_POS : SIGN_NEG;
        if (pick < 14)
            second_cls = (first_cls == SIGN_POS) ? SIGN_NEG : SIGN_POS;
        else if (pick < 16)
            second_cls = first_cls;
        else
        begin
            first_cls = random_class();
            second_cls = SIGN_ZERO;
            if (pick[0])
                {first_cls, second_cls} = {second_cls, first_cls};
        end
        rq.kind = REQ_VALUE;
        for (int i = 0; i < n_mid + 2; i++)
        begin
            rq.lo = $urandom;
            rq.hi = $urandom;
            if (i == 0)
                rq.fv = value_of_class(first_cls);
            else if (i == 1)
                rq.fv = value_of_class(second_cls);
            else
                rq.fv = value_of_class(random_class());
            send_beat(rq, 1'b0, none);
        end
    endtask

    // Mostly well-formed searches with random content, plus stray value beats,
    // lone starts and short searches that the next start cuts off.
    task automatic run_searches(input int quota, input int max_mid);
        request_t rq;
        answer_t  none;
        int       goal;
        none = '0;
        goal = useful_beats + quota;
        while (useful_beats < goal)
        begin
            case ($urandom_range(0, 15))
                0:
                begin
                    rq.kind = REQ_VALUE;
                    rq.lo = $urandom;
                    rq.hi = $urandom;
                    rq.fv = $urandom;
                    send_beat(rq, 1'b0, none);
                end
                1:
                begin
                    rq.kind = REQ_START;
                    rq.lo = $urandom;
                    rq.hi = $urandom;
                    rq.fv = $urandom;
                    searches_started++;
                    send_beat(rq, 1'b0, none);
                end
                2:
                    one_search($urandom_range(0, 2), 1'b0);
                default:
                    one_search($urandom_range(1, max_mid), 1'b0);
            endcase
        end
    endtask

    // Result sink. It follows its own stall pattern, and on request holds off
    // for a long stretch so the block backs up and stalls its input.
    initial
    begin : result_sink
        int step;
        step = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_req <= 1'b0;
            end
            else
            begin
                step++;
                case (sink_mode)
                    SINK_ALWAYS:  m_axis_tready <= 1'b1;
                    SINK_RANDOM:  m_axis_tready <= ($urandom_range(0, 1) == 1);
                    SINK_PATTERN: m_axis_tready <= (step % 4) != 3;
                    default:      m_axis_tready <= (step % 5) == 0;
                endcase
            end
        end
    end

    // Result checker: every accepted result beat is matched against the
    // oldest outstanding expectation, field by field.
    always @(posedge clk)
    begin : result_check
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (m_axis_tuser < 5)
                status_tally[m_axis_tuser]++;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing expected: status %0d", $time,
                         m_axis_tuser);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d, got %0d", $time, want.status,
                             m_axis_tuser);
                end
                if (m_axis_tdata[VALUE_W-1:0] !== want.eval_point)
                begin
                    mismatches++;
                    $display("%0t: eval_point expected %h, got %h", $time, want.eval_point,
                             m_axis_tdata[VALUE_W-1:0]);
                end
                if (m_axis_tdata[2*VALUE_W-1:VALUE_W] !== want.root)
                begin
                    mismatches++;
                    $display("%0t: root expected %h, got %h", $time, want.root,
                             m_axis_tdata[2*VALUE_W-1:VALUE_W]);
                end
            end
        end
    end

    initial
    begin : stimulus
        request_t rq;
        answer_t  typed_ans;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_START;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ABS_TOL;
        cfg_data = '0;
        hold_req = 1'b0;
        sink_mode = SINK_RANDOM;
        gaps_on = 1'b1;
        burst_left = 4;
        mismatches = 0;
        useful_beats = 0;
        searches_started = 0;
        foreach (status_tally[i])
            status_tally[i] = 0;

        // Predictor starts from the reset values of the block.
        abs_tol = ABS_TOL_RESET;
        rel_tol = REL_TOL_RESET;
        iter_limit = LIMIT_RESET;
        neg_end = '0;
        pos_end = '0;
        held_upper = '0;
        first_sign = SIGN_ZERO;
        mid_count = '0;
        search_phase = PH_IDLE;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under the reset configuration.
        foreach (directed_rows[i])
        begin
            rq.kind = directed_rows[i].kind;
            rq.lo = directed_rows[i].lo;
            rq.hi = directed_rows[i].hi;
            rq.fv = directed_rows[i].fv;
            typed_ans.status = directed_rows[i].status;
            typed_ans.eval_point = directed_rows[i].eval_point;
            typed_ans.root = directed_rows[i].root;
            if (rq.kind == REQ_START)
                searches_started++;
            send_beat(rq, directed_rows[i].typed, typed_ans);
        end
        wait_quiet();

        // Reset-like tolerances written explicitly, steady stall pattern.
        set_search_limits(31'd1, 16'd0, 8'd64);
        sink_mode = SINK_PATTERN;
        run_searches(70, 40);
        wait_quiet();

        // Zero tolerances never converge: one search runs until the midpoint
        // count saturates at the top of its range. No idling on either side.
        set_search_limits(31'd0, 16'd0, 8'd255);
        sink_mode = SINK_ALWAYS;
        gaps_on = 1'b0;
        one_search(260, 1'b1);
        wait_quiet();

        // Largest tolerances with a zero limit, receiver mostly stalled.
        set_search_limits(31'h7FFF_FFFF, 16'hFFFF, 8'd0);
        sink_mode = SINK_SPARSE;
        gaps_on = 1'b1;
        run_searches(35, 3);
        wait_quiet();

        // Back-to-back sender against a long receiver hold-off.
        set_search_limits(ABS_TOL_W'($urandom_range(0, 32'h0003_FFFF)),
                          REL_TOL_W'($urandom),
                          LIMIT_W'($urandom_range(1, 40)));
        sink_mode = SINK_RANDOM;
        gaps_on = 1'b0;
        hold_req <= 1'b1;
        run_searches(70, 30);
        wait_quiet();

        // Fully random configuration.
        set_search_limits(ABS_TOL_W'($urandom), REL_TOL_W'($urandom), LIMIT_W'($urandom));
        gaps_on = 1'b1;
        run_searches(35, 40);
        wait_quiet();

        // Small limit, so the limit status comes up often.
        set_search_limits(31'd1, 16'd0, 8'd8);
        sink_mode = SINK_ALWAYS;
        run_searches(35, 12);
        wait_quiet();

        $display("Ran %0d searches over %0d answered beats; results: %0d eval, %0d converged,",
                 searches_started, useful_beats, status_tally[ST_EVAL], status_tally[ST_CONV]);
        $display("%0d limit, %0d no sign change, %0d ignored; %0d mismatches.",
                 status_tally[ST_LIMIT], status_tally[ST_NOSIGN], status_tally[ST_IGNORED],
                 mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bisr_pkg.sv
rtl/bisr_conv.sv
rtl/bisection_root_search.sv
test/testbench.sv
